>>> rtl/wfp_pkg.sv
// wfp_pkg: shared widths, codes, entry type and helpers of the weighted picker.
// Used by every file of the picker and by its checker.
// No dependencies.
package wfp_pkg;

    // table geometry
    localparam int ENTRIES   = 64;
    localparam int GROUPS    = 3;

    // field widths
    localparam int OP_W      = 3;
    localparam int STAT_W    = 3;
    localparam int GID_W     = 32;
    localparam int WGT_W     = 32;
    localparam int MEM_W     = 48;
    localparam int COEF_W    = 17;
    localparam int RND_W     = 31;
    localparam int OUT_TOT_W = 39;
    localparam int FRAC_W    = 16;

    // derived widths
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int PCNT_W    = $clog2(GROUPS + 2);
    localparam int EFF_W     = WGT_W + COEF_W - FRAC_W;
    localparam int SUM_W     = EFF_W + $clog2(ENTRIES);
    localparam int TOT_W     = (SUM_W > OUT_TOT_W) ? SUM_W : OUT_TOT_W + 1;
    localparam int HALF_W    = (TOT_W + 1) / 2;
    localparam int HI_W      = TOT_W - HALF_W;
    localparam int PROD_W    = RND_W + TOT_W;
    localparam int DIV_STEPS = 4;   // three folds and a final compare
    localparam int DIV_W     = $clog2(DIV_STEPS);

    // stream payload layout, lowest field first
    localparam int S_GID_LO  = 0;
    localparam int S_WGT_LO  = S_GID_LO + GID_W;
    localparam int S_MEM_LO  = S_WGT_LO + WGT_W;
    localparam int S_COEF_LO = S_MEM_LO + MEM_W;
    localparam int S_SIZE_LO = S_COEF_LO + COEF_W;
    localparam int S_RND_LO  = S_SIZE_LO + MEM_W;
    localparam int S_FIELD_W = S_RND_LO + RND_W;
    localparam int S_DATA_W  = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W = GID_W + WGT_W + MEM_W + OUT_TOT_W;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    // constants
    localparam logic [COEF_W-1:0] ONE_Q16 = COEF_W'(1 << FRAC_W);
    localparam logic [RND_W-1:0]  RMAX    = {RND_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_ADD    = 3'd1,
        OP_COMMIT = 3'd2,
        OP_COEF   = 3'd3,
        OP_SELECT = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_NOMEM    = 3'd1,
        STAT_MISMATCH = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COEF,
        S_SUM,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV,
        S_PICK
    } state_t;

    typedef struct packed {
        logic [GROUPS-1:0][GID_W-1:0] groups;
        logic [WGT_W-1:0]             weight;
        logic [MEM_W-1:0]             memory;
        logic [COEF_W-1:0]            coef;
    } entry_t;

    typedef struct packed {
        logic rotate;
        logic commit;
    } cell_ctl_t;

    // smallest group id held by an entry
    function automatic logic [GID_W-1:0] min_group(input entry_t e);
        logic [GID_W-1:0] m;
        m = e.groups[0];
        for (int g = 1; g < GROUPS; g++)
        begin
            if (e.groups[g] < m)
                m = e.groups[g];
        end
        return m;
    endfunction

endpackage

>>> rtl/weighted_capacity_filtered_picker.sv
// weighted_capacity_filtered_picker: top level, ring of entry cells plus control.
// Depends on wfp_pkg and wfp_cell.
//
//  channel | dir | fields
//  s_*     | in  | tuser: op; tdata: group_id, weight, memory, coefficient, size, random_value
//  m_*     | out | tuser: status; tdata: chosen_id, chosen_weight, chosen_memory, weight_sum
//
// Clear, add, commit and unused ops finish in the transfer cycle.
// Lower coefficient takes one full turn of the cell ring.
// Select runs a ring turn to sum weights, two partial products, three folds and a
// compare to divide by 2^31-1, and a second turn to pick.
// Reset clears the entry and pending counts; no clearing pass. s_tready holds low
// while a result waits on a stalled m_tready or an op is in progress.
module weighted_capacity_filtered_picker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wfp_pkg::OP_W-1:0]        s_tuser,  // op
    input  logic [wfp_pkg::S_DATA_W-1:0]    s_tdata,  // group_id, weight, memory, coefficient,
                                                      // size, random_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wfp_pkg::STAT_W-1:0]      m_tuser,  // status
    output logic [wfp_pkg::M_DATA_W-1:0]    m_tdata   // chosen_id, chosen_weight,
                                                      // chosen_memory, weight_sum
);
    import wfp_pkg::*;

    // control state
    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              step_reg, step_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [PCNT_W-1:0]             pcnt_reg, pcnt_next;
    logic [DIV_W-1:0]              div_cnt_reg, div_cnt_next;
    logic                          found_reg, found_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          pipe_q_reg, pipe_q_next;

    // payload
    logic [GROUPS-1:0][GID_W-1:0]  pend_reg, pend_next;
    logic [GID_W-1:0]              gid_reg, gid_next;
    logic [COEF_W-1:0]             coef_reg, coef_next;
    logic [MEM_W-1:0]              size_reg, size_next;
    logic [RND_W-1:0]              rnd_reg, rnd_next;
    logic [TOT_W-1:0]              total_reg, total_next;
    logic [TOT_W-1:0]              run_reg, run_next;
    logic [PROD_W-1:0]             prod_reg, prod_next;
    logic [TOT_W-1:0]              quo_reg, quo_next;
    logic [EFF_W-1:0]              pipe_eff_reg, pipe_eff_next;
    logic [GID_W-1:0]              pipe_id_reg, pipe_id_next;
    logic [WGT_W-1:0]              pipe_w_reg, pipe_w_next;
    logic [MEM_W-1:0]              pipe_mem_reg, pipe_mem_next;
    logic [GID_W-1:0]              ch_id_reg, ch_id_next;
    logic [WGT_W-1:0]              ch_w_reg, ch_w_next;
    logic [MEM_W-1:0]              ch_mem_reg, ch_mem_next;
    logic [STAT_W-1:0]             o_stat_reg, o_stat_next;
    logic [GID_W-1:0]              o_id_reg, o_id_next;
    logic [WGT_W-1:0]              o_w_reg, o_w_next;
    logic [MEM_W-1:0]              o_mem_reg, o_mem_next;
    logic [OUT_TOT_W-1:0]          o_tot_reg, o_tot_next;

    // ring
    entry_t                        cell_ent [ENTRIES];
    logic [ENTRIES-1:0]            cell_ge;
    entry_t                        new_ent, head, head_mod;
    cell_ctl_t                     ctl;

    // datapath helpers
    logic                          accept;
    logic [WGT_W+COEF_W-1:0]       eff_full;
    logic                          head_match, coef_hit, head_q;
    logic [RND_W+HALF_W-1:0]       prod_lo;
    logic [RND_W+HI_W-1:0]         prod_hi;
    logic [TOT_W-1:0]              fold_hi;
    logic [TOT_W-1:0]              run_sum;
    logic [OUT_TOT_W-1:0]          tot_sat;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = o_stat_reg;
    assign m_tdata  = M_DATA_W'({o_tot_reg, o_mem_reg, o_w_reg, o_id_reg});

    // entry being committed
    always_comb
    begin
        new_ent.groups = pend_reg;
        new_ent.weight = s_tdata[S_WGT_LO +: WGT_W];
        new_ent.memory = s_tdata[S_MEM_LO +: MEM_W];
        new_ent.coef   = ONE_Q16;
    end

    // head of the ring and the coefficient update on its way round
    assign head = cell_ent[0];

    always_comb
    begin
        head_match = 1'b0;
        for (int g = 0; g < GROUPS; g++)
        begin
            if (head.groups[g] == gid_reg)
                head_match = 1'b1;
        end
        coef_hit = (state_reg == S_COEF) && (step_reg < count_reg) && head_match
                   && !found_reg;
        head_mod = head;
        if (coef_hit && (coef_reg < head.coef))
            head_mod.coef = coef_reg;
    end

    assign ctl.rotate = (state_reg == S_COEF)
                        || (((state_reg == S_SUM) || (state_reg == S_PICK))
                            && (step_reg < CNT_W'(ENTRIES)));
    assign ctl.commit = accept && (op_t'(s_tuser) == OP_COMMIT)
                        && (pcnt_reg == PCNT_W'(GROUPS))
                        && (count_reg < CNT_W'(ENTRIES));

    // cell chain
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        wfp_cell u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .ring_in ((i == ENTRIES - 1) ? head_mod : cell_ent[(i + 1) % ENTRIES]),
            .prev_ent((i == 0) ? new_ent : cell_ent[(i + ENTRIES - 1) % ENTRIES]),
            .new_ent (new_ent),
            .occ     (count_reg > CNT_W'(i)),
            .ge_prev ((i == 0) ? 1'b1 : cell_ge[(i + ENTRIES - 1) % ENTRIES]),
            .ent     (cell_ent[i]),
            .ge      (cell_ge[i])
        );
    end

    // effective weight of the head, qualification against the requested size
    assign eff_full = head.weight * head.coef;
    assign head_q   = (step_reg < count_reg) && (head.memory >= size_reg);

    // arithmetic pieces
    assign prod_lo  = rnd_reg * total_reg[HALF_W-1:0];
    assign prod_hi  = rnd_reg * total_reg[TOT_W-1:HALF_W];
    assign fold_hi  = prod_reg[PROD_W-1:RND_W];
    assign run_sum  = run_reg + TOT_W'(pipe_eff_reg);
    assign tot_sat  = (|total_reg[TOT_W-1:OUT_TOT_W]) ? {OUT_TOT_W{1'b1}}
                                                      : total_reg[OUT_TOT_W-1:0];

    // next state and result
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        pcnt_next      = pcnt_reg;
        div_cnt_next   = div_cnt_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        pipe_q_next    = pipe_q_reg;
        pend_next      = pend_reg;
        gid_next       = gid_reg;
        coef_next      = coef_reg;
        size_next      = size_reg;
        rnd_next       = rnd_reg;
        total_next     = total_reg;
        run_next       = run_reg;
        prod_next      = prod_reg;
        quo_next       = quo_reg;
        pipe_eff_next  = eff_full[WGT_W+COEF_W-1:FRAC_W];
        pipe_id_next   = min_group(head);
        pipe_w_next    = head.weight;
        pipe_mem_next  = head.memory;
        ch_id_next     = ch_id_reg;
        ch_w_next      = ch_w_reg;
        ch_mem_next    = ch_mem_reg;
        o_stat_next    = o_stat_reg;
        o_id_next      = o_id_reg;
        o_w_next       = o_w_reg;
        o_mem_next     = o_mem_reg;
        o_tot_next     = o_tot_reg;

        if (m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    gid_next       = s_tdata[S_GID_LO +: GID_W];
                    coef_next      = s_tdata[S_COEF_LO +: COEF_W];
                    size_next      = s_tdata[S_SIZE_LO +: MEM_W];
                    rnd_next       = s_tdata[S_RND_LO +: RND_W];
                    step_next      = '0;
                    found_next     = 1'b0;
                    pipe_q_next    = 1'b0;
                    total_next     = '0;
                    o_stat_next    = STAT_OK;
                    o_id_next      = '0;
                    o_w_next       = '0;
                    o_mem_next     = '0;
                    o_tot_next     = '0;
                    out_valid_next = 1'b1;
                    case (op_t'(s_tuser))
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            pcnt_next  = '0;
                        end
                        OP_ADD:
                        begin
                            for (int g = 0; g < GROUPS; g++)
                            begin
                                if (pcnt_reg == PCNT_W'(g))
                                    pend_next[g] = s_tdata[S_GID_LO +: GID_W];
                            end
                            if (pcnt_reg <= PCNT_W'(GROUPS))
                                pcnt_next = pcnt_reg + 1'b1;
                        end
                        OP_COMMIT:
                        begin
                            pcnt_next = '0;
                            if (pcnt_reg != PCNT_W'(GROUPS))
                                o_stat_next = STAT_MISMATCH;
                            else if (count_reg >= CNT_W'(ENTRIES))
                                o_stat_next = STAT_FULL;
                            else
                                count_next = count_reg + 1'b1;
                        end
                        OP_COEF:
                        begin
                            out_valid_next = 1'b0;
                            state_next     = S_COEF;
                        end
                        OP_SELECT:
                        begin
                            out_valid_next = 1'b0;
                            state_next     = S_SUM;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // one ring turn, first holder of the group gets the lower coefficient
            S_COEF:
            begin
                if (coef_hit)
                    found_next = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == CNT_W'(ENTRIES - 1))
                begin
                    o_stat_next    = found_next ? STAT_OK : STAT_NOTFOUND;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            // ring turn summing effective weights at or above the size cut
            S_SUM:
            begin
                pipe_q_next = ctl.rotate && head_q;
                if (pipe_q_reg)
                    total_next = total_reg + TOT_W'(pipe_eff_reg);
                step_next = step_reg + 1'b1;
                if (step_reg == CNT_W'(ENTRIES))
                begin
                    if (total_next == '0)
                    begin
                        o_stat_next    = STAT_NOMEM;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                        state_next = S_MUL_LO;
                end
            end

            // random_value * total in two partial products
            S_MUL_LO:
            begin
                prod_next  = PROD_W'(prod_lo);
                state_next = S_MUL_HI;
            end

            S_MUL_HI:
            begin
                prod_next    = prod_reg + (PROD_W'(prod_hi) << HALF_W);
                quo_next     = '0;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end

            // divide by 2^31-1: fold the bits above bit 30 back in, then one compare
            S_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg != DIV_W'(DIV_STEPS - 1))
                begin
                    quo_next  = quo_reg + fold_hi;
                    prod_next = PROD_W'(fold_hi) + PROD_W'(prod_reg[RND_W-1:0]);
                end
                else
                begin
                    if (prod_reg >= PROD_W'(RMAX))
                        quo_next = quo_reg + 1'b1;
                    step_next   = '0;
                    run_next    = '0;
                    found_next  = 1'b0;
                    pipe_q_next = 1'b0;
                    state_next  = S_PICK;
                end
            end

            // second ring turn: first running sum reaching the shoot point
            S_PICK:
            begin
                pipe_q_next = ctl.rotate && head_q;
                if (pipe_q_reg && (pipe_eff_reg != '0) && !found_reg)
                begin
                    run_next = run_sum;
                    if (run_sum >= quo_reg)
                    begin
                        found_next  = 1'b1;
                        ch_id_next  = pipe_id_reg;
                        ch_w_next   = pipe_w_reg;
                        ch_mem_next = pipe_mem_reg;
                    end
                end
                step_next = step_reg + 1'b1;
                if (step_reg == CNT_W'(ENTRIES))
                begin
                    o_stat_next    = STAT_OK;
                    o_id_next      = ch_id_next;
                    o_w_next       = ch_w_next;
                    o_mem_next     = ch_mem_next;
                    o_tot_next     = tot_sat;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            pcnt_reg      <= '0;
            div_cnt_reg   <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            pipe_q_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            pcnt_reg      <= pcnt_next;
            div_cnt_reg   <= div_cnt_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            pipe_q_reg    <= pipe_q_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        gid_reg      <= gid_next;
        coef_reg     <= coef_next;
        size_reg     <= size_next;
        rnd_reg      <= rnd_next;
        total_reg    <= total_next;
        run_reg      <= run_next;
        prod_reg     <= prod_next;
        quo_reg      <= quo_next;
        pipe_eff_reg <= pipe_eff_next;
        pipe_id_reg  <= pipe_id_next;
        pipe_w_reg   <= pipe_w_next;
        pipe_mem_reg <= pipe_mem_next;
        ch_id_reg    <= ch_id_next;
        ch_w_reg     <= ch_w_next;
        ch_mem_reg   <= ch_mem_next;
        o_stat_reg   <= o_stat_next;
        o_id_reg     <= o_id_next;
        o_w_reg      <= o_w_next;
        o_mem_reg    <= o_mem_next;
        o_tot_reg    <= o_tot_next;
    end

endmodule

>>> rtl/wfp_cell.sv
// wfp_cell: one slot of the entry ring.
// Rotates towards the head or makes room for a sorted insert. Depends on wfp_pkg.
module wfp_cell (
    input  logic               clk,
    input  wfp_pkg::cell_ctl_t ctl,
    input  wfp_pkg::entry_t    ring_in,   // from the neighbour behind
    input  wfp_pkg::entry_t    prev_ent,  // from the neighbour in front
    input  wfp_pkg::entry_t    new_ent,   // entry being committed
    input  logic               occ,       // slot lies below the entry count
    input  logic               ge_prev,   // front neighbour stays put
    output wfp_pkg::entry_t    ent,
    output logic               ge
);
    import wfp_pkg::*;

    entry_t ent_reg;

    // slot keeps its place on insert when it holds at least as much memory
    assign ge  = occ && (ent_reg.memory >= new_ent.memory);
    assign ent = ent_reg;

    // rotate one place, or take the new entry, or shift down behind it
    always_ff @(posedge clk)
    begin
        if (ctl.rotate)
            ent_reg <= ring_in;
        else if (ctl.commit)
        begin
            if (ge_prev && !ge)
                ent_reg <= new_ent;
            else if (!ge_prev)
                ent_reg <= prev_ent;
        end
    end

endmodule

>>> rtl/wfp_checker.sv
// wfp_checker: port-level assertions for the weighted picker, bound to the top level.
// Depends on wfp_pkg.
module wfp_port_assertions (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [wfp_pkg::OP_W-1:0]     s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [wfp_pkg::STAT_W-1:0]   m_tuser,
    input logic [wfp_pkg::M_DATA_W-1:0] m_tdata
);
    import wfp_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no new transfer in while a result is stuck
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

    // status codes are in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STAT_OK) || (m_tuser == STAT_NOMEM)
                     || (m_tuser == STAT_MISMATCH) || (m_tuser == STAT_FULL)
                     || (m_tuser == STAT_NOTFOUND))
        else $error("bad status");

    // failures carry no pick
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STAT_OK) |-> m_tdata == '0)
        else $error("failed result carries data");

endmodule

bind weighted_capacity_filtered_picker wfp_port_assertions u_wfp_port_assertions (.*);

>>> tb/sv/wfp_checker.sv
// wfp_checker: watches both stream channels of the weighted picker, predicts each
// result from the accepted input transfers and compares field by field.
// Depends on wfp_pkg.
`timescale 1ns / 1ps

module wfp_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [wfp_pkg::OP_W-1:0]      s_tuser,
    input  logic [wfp_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [wfp_pkg::STAT_W-1:0]    m_tuser,
    input  logic [wfp_pkg::M_DATA_W-1:0]  m_tdata,
    output int                            errors,
    output int                            outstanding
);
    import wfp_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [GID_W-1:0]     chosen_id;
        logic [WGT_W-1:0]     chosen_weight;
        logic [MEM_W-1:0]     chosen_memory;
        logic [OUT_TOT_W-1:0] weight_sum;
    } pick_result_t;

    localparam longint unsigned RANGE_MAX = longint'(RMAX);
    localparam longint unsigned TOT_SAT   = (64'd1 << OUT_TOT_W) - 1;

    // shadow copy of the entry table and the pending entry
    logic [GID_W-1:0]  tbl_groups [ENTRIES][GROUPS];
    logic [WGT_W-1:0]  tbl_weight [ENTRIES];
    logic [MEM_W-1:0]  tbl_memory [ENTRIES];
    logic [COEF_W-1:0] tbl_coef   [ENTRIES];
    int                tbl_count;
    logic [GID_W-1:0]  load_groups [GROUPS];
    int                load_count;

    pick_result_t      pending_picks [$];

    function automatic longint unsigned scaled_weight(int i);
        longint unsigned prod;
        prod = longint'(tbl_weight[i]) * longint'(tbl_coef[i]);
        return prod >> FRAC_W;
    endfunction

    // apply one accepted operation to the shadow table, return its result
    function automatic pick_result_t apply_op(logic [OP_W-1:0] op, logic [S_DATA_W-1:0] d);
        pick_result_t      r;
        logic [GID_W-1:0]  gid;
        logic [WGT_W-1:0]  wgt;
        logic [MEM_W-1:0]  mem;
        logic [COEF_W-1:0] coef;
        logic [MEM_W-1:0]  need;
        longint unsigned   rnd, total, q, rem, shoot, run, e;
        int                pos, lim, pick;
        bit                found;
        gid  = d[S_GID_LO  +: GID_W];
        wgt  = d[S_WGT_LO  +: WGT_W];
        mem  = d[S_MEM_LO  +: MEM_W];
        coef = d[S_COEF_LO +: COEF_W];
        need = d[S_SIZE_LO +: MEM_W];
        rnd  = longint'(d[S_RND_LO +: RND_W]);
        r    = '0;
        r.status = STAT_OK;
        case (op)
            OP_CLEAR:
            begin
                tbl_count  = 0;
                load_count = 0;
            end
            OP_ADD:
            begin
                if (load_count < GROUPS)
                    load_groups[load_count] = gid;
                if (load_count <= GROUPS)
                    load_count++;
            end
            OP_COMMIT:
            begin
                if (load_count != GROUPS)
                    r.status = STAT_MISMATCH;
                else if (tbl_count >= ENTRIES)
                    r.status = STAT_FULL;
                else
                begin
                    // insert after every entry with at least as much memory
                    pos = 0;
                    while (pos < tbl_count && tbl_memory[pos] >= mem)
                        pos++;
                    for (int i = tbl_count; i > pos; i--)
                    begin
                        tbl_groups[i] = tbl_groups[i-1];
                        tbl_weight[i] = tbl_weight[i-1];
                        tbl_memory[i] = tbl_memory[i-1];
                        tbl_coef[i]   = tbl_coef[i-1];
                    end
                    tbl_groups[pos] = load_groups;
                    tbl_weight[pos] = wgt;
                    tbl_memory[pos] = mem;
                    tbl_coef[pos]   = ONE_Q16;
                    tbl_count++;
                end
                load_count = 0;
            end
            OP_COEF:
            begin
                found = 0;
                for (int i = 0; i < tbl_count && !found; i++)
                begin
                    for (int g = 0; g < GROUPS; g++)
                    begin
                        if (!found && tbl_groups[i][g] == gid)
                        begin
                            if (coef < tbl_coef[i])
                                tbl_coef[i] = coef;
                            found = 1;
                        end
                    end
                end
                if (!found)
                    r.status = STAT_NOTFOUND;
            end
            OP_SELECT:
            begin
                total = 0;
                lim   = 0;
                while (lim < tbl_count && tbl_memory[lim] >= need)
                begin
                    total += scaled_weight(lim);
                    lim++;
                end
                if (total == 0)
                    r.status = STAT_NOMEM;
                else
                begin
                    q     = total / RANGE_MAX;
                    rem   = total % RANGE_MAX;
                    shoot = rnd * q + (rnd * rem) / RANGE_MAX;
                    run   = 0;
                    pick  = lim - 1;
                    for (int i = 0; i < lim; i++)
                    begin
                        e = scaled_weight(i);
                        if (e != 0)
                        begin
                            run += e;
                            if (run >= shoot)
                            begin
                                pick = i;
                                break;
                            end
                        end
                    end
                    r.chosen_id = tbl_groups[pick][0];
                    for (int g = 1; g < GROUPS; g++)
                    begin
                        if (tbl_groups[pick][g] < r.chosen_id)
                            r.chosen_id = tbl_groups[pick][g];
                    end
                    r.chosen_weight = tbl_weight[pick];
                    r.chosen_memory = tbl_memory[pick];
                    r.weight_sum    = (total > TOT_SAT) ? TOT_SAT : total;
                end
            end
            default:
            begin
                // unused ops leave everything alone
            end
        endcase
        return r;
    endfunction

    assign outstanding = pending_picks.size();

    // predict on input transfers first, then compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        pick_result_t want, got;
        if (!rst_n)
        begin
            tbl_count  = 0;
            load_count = 0;
            errors     <= 0;
            pending_picks.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                pending_picks.push_back(apply_op(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                got.status        = m_tuser;
                got.chosen_id     = m_tdata[0 +: GID_W];
                got.chosen_weight = m_tdata[GID_W +: WGT_W];
                got.chosen_memory = m_tdata[GID_W + WGT_W +: MEM_W];
                got.weight_sum    = m_tdata[GID_W + WGT_W + MEM_W +: OUT_TOT_W];
                if (pending_picks.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d id=%h", $realtime,
                             got.status, got.chosen_id);
                    errors <= errors + 1;
                end
                else
                begin
                    want = pending_picks.pop_front();
                    if (got.status != want.status)
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 want.status, got.status);
                    if (got.chosen_id != want.chosen_id)
                        $display("%0t: chosen_id expected %h actual %h", $realtime,
                                 want.chosen_id, got.chosen_id);
                    if (got.chosen_weight != want.chosen_weight)
                        $display("%0t: chosen_weight expected %h actual %h", $realtime,
                                 want.chosen_weight, got.chosen_weight);
                    if (got.chosen_memory != want.chosen_memory)
                        $display("%0t: chosen_memory expected %h actual %h", $realtime,
                                 want.chosen_memory, got.chosen_memory);
                    if (got.weight_sum != want.weight_sum)
                        $display("%0t: weight_sum expected %h actual %h", $realtime,
                                 want.weight_sum, got.weight_sum);
                    if (got != want)
                        errors <= errors + 1;
                end
            end
        end
    end

endmodule

>>> tb/sv/testbench.sv
// testbench: stimulus and verdict for weighted_capacity_filtered_picker.
// Depends on wfp_pkg, the picker RTL and wfp_checker.
`timescale 1ns / 1ps

module testbench;
    import wfp_pkg::*;

    localparam int          CYCLE_LIMIT  = 1500000;
    localparam int          RANDOM_ITEMS = 1500;
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
    localparam logic [COEF_W-1:0] COEF_TOP = {COEF_W{1'b1}};

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [OP_W-1:0]     s_tuser;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [STAT_W-1:0]   m_tuser;
    logic [M_DATA_W-1:0] m_tdata;
    int                  errors;
    int                  outstanding;
    int                  cycles;
    int                  sent;
    bit                  quiet;

    logic [GID_W-1:0]    id_pool  [16];
    logic [MEM_W-1:0]    mem_pool [8];

    weighted_capacity_filtered_picker uut (.*);

    wfp_checker checker_i (.*);

    initial clk = 0;
    always #5 clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[weighted_capacity_filtered_picker] ERROR");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= quiet || ($urandom_range(99) >= 28);
    end

    function automatic logic [MEM_W-1:0] rand48();
        return MEM_W'({$urandom, $urandom});
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic push_op(logic [OP_W-1:0] op, logic [GID_W-1:0] gid,
                           logic [WGT_W-1:0] wgt, logic [MEM_W-1:0] mem,
                           logic [COEF_W-1:0] coef, logic [MEM_W-1:0] need,
                           logic [RND_W-1:0] rnd);
        logic [S_DATA_W-1:0] d;
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        d = '0;
        d[S_GID_LO  +: GID_W]  = gid;
        d[S_WGT_LO  +: WGT_W]  = wgt;
        d[S_MEM_LO  +: MEM_W]  = mem;
        d[S_COEF_LO +: COEF_W] = coef;
        d[S_SIZE_LO +: MEM_W]  = need;
        d[S_RND_LO  +: RND_W]  = rnd;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    function automatic logic [GID_W-1:0] pick_id();
        return ($urandom_range(9) < 8) ? id_pool[$urandom_range(15)] : $urandom;
    endfunction

    function automatic logic [WGT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MEM_W-1:0] pick_mem();
        return ($urandom_range(9) < 7) ? mem_pool[$urandom_range(7)] : rand48();
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(7))
            0:       return '0;
            1:       return ONE_Q16;
            2:       return COEF_W'($urandom);
            default: return COEF_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [RND_W-1:0] pick_rnd();
        case ($urandom_range(9))
            0:       return '0;
            1:       return RMAX;
            default: return RND_W'($urandom);
        endcase
    endfunction

    // three group ids and a commit
    task automatic load_entry();
        for (int g = 0; g < GROUPS; g++)
            push_op(OP_ADD, pick_id(), $urandom, rand48(), COEF_W'($urandom), rand48(),
                    RND_W'($urandom));
        push_op(OP_COMMIT, $urandom, pick_weight(), pick_mem(), COEF_W'($urandom),
                rand48(), RND_W'($urandom));
    endtask

    task automatic do_select();
        push_op(OP_SELECT, $urandom, $urandom, rand48(), COEF_W'($urandom),
                ($urandom_range(4) == 0) ? rand48() : pick_mem(), pick_rnd());
    endtask

    initial
    begin
        int n;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = '0;
        s_tdata  = '0;
        m_tready = 1'b0;
        cycles   = 0;
        sent     = 0;
        quiet    = 0;
        for (int i = 0; i < 16; i++)
            id_pool[i] = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
        for (int i = 0; i < 8; i++)
            mem_pool[i] = (i == 0) ? '0 : (i == 1) ? '1 : rand48();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed: select on an empty table, extremes, odd cases
        push_op(OP_SELECT, '0, '0, '0, '0, '0, RMAX);
        push_op(OP_COMMIT, '0, '1, '1, '0, '0, '0);
        push_op(OP_ADD, '1, '0, '0, '0, '0, '0);
        push_op(OP_ADD, '0, '0, '0, '0, '0, '0);
        push_op(OP_ADD, 32'h8000_0001, '0, '0, '0, '0, '0);
        push_op(OP_COMMIT, '0, '1, '1, '0, '0, '0);
        push_op(OP_ADD, 32'd7, '0, '0, '0, '0, '0);
        push_op(OP_ADD, 32'd5, '0, '0, '0, '0, '0);
        push_op(OP_ADD, 32'd9, '0, '0, '0, '0, '0);
        push_op(OP_ADD, 32'd3, '0, '0, '0, '0, '0);
        push_op(OP_COMMIT, '0, 32'd100, 48'd10, '0, '0, '0);
        push_op(OP_SELECT, '0, '0, '0, '0, '0, '0);
        push_op(OP_SELECT, '0, '0, '0, '0, '1, RMAX);
        push_op(OP_COEF, 32'h8000_0001, '0, '0, COEF_TOP, '0, '0);
        push_op(OP_COEF, '0, '0, '0, 17'd1, '0, '0);
        push_op(OP_SELECT, '0, '0, '0, '0, '0, 31'd12345);
        push_op(OP_COEF, 32'h8000_0001, '0, '0, '0, '0, '0);
        push_op(OP_SELECT, '0, '0, '0, '0, '0, RMAX);
        push_op(OP_COEF, 32'hdead_beef, '0, '0, '0, '0, '0);
        for (logic [OP_W-1:0] op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
        begin
            push_op(op, '1, '1, '1, COEF_TOP, '1, RMAX);
            if (op == OP_UNUSED_LAST)
                break;
        end
        push_op(OP_CLEAR, '1, '1, '1, COEF_TOP, '1, RMAX);
        push_op(OP_SELECT, '0, '0, '0, '0, '0, RMAX);

        // random: mostly well-formed entry loads with selects and coefficient drops
        n = 0;
        while (sent < RANDOM_ITEMS)
        begin
            quiet = (n >= 100 && n < 200);
            if (n >= 300 && n < 305)
            begin
                // fill the table past its capacity, then pick from a full table
                push_op(OP_CLEAR, $urandom, $urandom, rand48(), '0, '0, '0);
                for (int k = 0; k < ENTRIES + 2; k++)
                    load_entry();
                for (int k = 0; k < 10; k++)
                    do_select();
                n += 5;
                continue;
            end
            if (n == 400)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                wait (outstanding == 0);
            end
            case ($urandom_range(99)) inside
                [0:37]:  load_entry();
                [38:45]:
                begin
                    repeat ($urandom_range(5))
                        push_op(OP_ADD, pick_id(), $urandom, rand48(), '0, '0, '0);
                    push_op(OP_COMMIT, $urandom, pick_weight(), pick_mem(), '0, '0, '0);
                end
                [46:62]: push_op(OP_COEF, pick_id(), $urandom, rand48(), pick_coef(),
                                 rand48(), RND_W'($urandom));
                [63:95]: do_select();
                [96:97]: push_op(OP_CLEAR, $urandom, $urandom, rand48(), '0, '0, '0);
                default: push_op(OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)),
                                 '0, '0, '0, '0, '0, '0);
            endcase
            n++;
        end
        quiet = 0;
        @(negedge clk);
        s_tvalid <= 1'b0;

        wait (outstanding == 0);
        repeat (250) @(posedge clk);
        if (errors == 0)
            $display("[weighted_capacity_filtered_picker] OK");
        else
            $display("[weighted_capacity_filtered_picker] ERROR");
        $finish;
    end

endmodule
